### design/was_pkg.sv
// ----------------------------------------------------------------------------
// was_pkg
// Types and constants for the weekly alarm scheduler.
// ----------------------------------------------------------------------------
package was_pkg;

  localparam int unsigned DIST_W = 16;
  localparam int unsigned NOW_W  = 14;

  localparam logic [NOW_W-1:0]         MIN_PER_DAY  = 14'd1440;
  localparam logic [NOW_W-1:0]         MIN_PER_HOUR = 14'd60;
  localparam logic signed [DIST_W-1:0] WEEK_WRAP    = 16'sd10079;
  localparam logic [DIST_W-1:0]        DIST_MAX     = 16'hFFFF;
  localparam logic [2:0]               LAST_DAY     = 3'd6;
  localparam logic [2:0]               NO_DAY       = 3'd7;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOW,
    ST_LOAD,
    ST_DAY,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic       enabled;
    logic [6:0] days;
    logic [4:0] hour;
    logic [5:0] minute;
  } entry_t;

endpackage

### design/was_if.sv
// ----------------------------------------------------------------------------
// was_if
// Request and result channels of the weekly alarm scheduler.
// ----------------------------------------------------------------------------
interface was_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] slot;
  logic       alarm_enabled;
  logic [6:0] alarm_days;
  logic [4:0] alarm_hour;
  logic [5:0] alarm_minute;
  logic [4:0] time_hour;
  logic [5:0] time_minute;
  logic [5:0] time_second;
  logic [2:0] weekday;
  logic       rescan;

  modport source (
    output valid, action, slot, alarm_enabled, alarm_days, alarm_hour, alarm_minute,
           time_hour, time_minute, time_second, weekday, rescan,
    input  ready
  );
  modport sink (
    input  valid, action, slot, alarm_enabled, alarm_days, alarm_hour, alarm_minute,
           time_hour, time_minute, time_second, weekday, rescan,
    output ready
  );
endinterface

interface was_out_if;
  logic       valid;
  logic       ready;
  logic       next_found;
  logic [2:0] next_slot;
  logic [2:0] next_weekday;
  logic       ringing;
  logic       ring_started;

  modport source (
    output valid, next_found, next_slot, next_weekday, ringing, ring_started,
    input  ready
  );
  modport sink (
    input  valid, next_found, next_slot, next_weekday, ringing, ring_started,
    output ready
  );
endinterface

### design/weekly_alarm_scheduler.sv
// ----------------------------------------------------------------------------
// weekly_alarm_scheduler
// Weekly alarm table with nearest-alarm search and ring control.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request returns one result.
// A time tick that needs no rescan goes from idle straight to the result
// state. A write, a stop, or a tick that rescans walks the table one
// slot-day pair per cycle, after a load state per slot, through a single
// add, wrap and compare unit; its result follows a final load state.
// The request side is ready again once the result is loaded into the output
// register; a result still waiting there holds the next request back only
// at its own result stage.
module weekly_alarm_scheduler #(
  parameter int unsigned ALARM_SLOTS = 5
) (
  input  logic clk,
  input  logic rst_n,
  was_in_if.sink    in_ch,
  was_out_if.source out_ch
);

  localparam int unsigned IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(ALARM_SLOTS + 1);
  localparam logic [3:0]  SLOTS_4 = 4'(ALARM_SLOTS);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(ALARM_SLOTS);

  was_pkg::state_t state_r, state_nxt;

  was_pkg::entry_t table_r [ALARM_SLOTS];
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_idx;
  was_pkg::entry_t  tbl_wdata;

  logic [4:0] cur_hour_r, cur_hour_nxt;
  logic [5:0] cur_min_r, cur_min_nxt;
  logic [2:0] cur_wday_r, cur_wday_nxt;

  logic       chosen_valid_r, chosen_valid_nxt;
  logic [2:0] chosen_slot_r, chosen_slot_nxt;
  logic [2:0] chosen_day_r, chosen_day_nxt;
  logic [6:0] chosen_days_r, chosen_days_nxt;
  logic [4:0] chosen_hour_r, chosen_hour_nxt;
  logic [5:0] chosen_min_r, chosen_min_nxt;
  logic       ring_r, ring_nxt;
  logic       started_r, started_nxt;

  logic [was_pkg::NOW_W-1:0]         now_r, now_nxt;
  logic [was_pkg::DIST_W-1:0]        best_r, best_nxt;
  logic signed [was_pkg::DIST_W-1:0] base_r, base_nxt;
  logic [was_pkg::NOW_W-1:0]         day_off_r, day_off_nxt;
  logic [2:0]                        day_r, day_nxt;
  logic [CNT_W-1:0]                  slot_cnt_r, slot_cnt_nxt;
  was_pkg::entry_t                   ent_r, ent_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_found_r, out_found_nxt;
  logic [2:0] out_slot_r, out_slot_nxt;
  logic [2:0] out_wday_r, out_wday_nxt;
  logic       out_ring_r, out_ring_nxt;
  logic       out_started_r, out_started_nxt;

  logic            accept;
  logic            go_scan;
  logic            out_free;
  was_pkg::action_t act;

  // tick evaluation against the chosen alarm
  logic day_on, match, ring_after, tick_start, tick_stop, tick_scan;

  // shared distance unit
  logic signed [was_pkg::DIST_W-1:0] dist_raw, dist_wrap;
  logic                              cand, better;

  assign in_ch.ready = (state_r == was_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign act         = was_pkg::action_t'(in_ch.action);
  assign out_free    = !out_valid_r || out_ch.ready;

  assign day_on     = (in_ch.weekday != was_pkg::NO_DAY) && chosen_days_r[in_ch.weekday];
  assign match      = chosen_valid_r && day_on && (chosen_hour_r == in_ch.time_hour) &&
                      (chosen_min_r == in_ch.time_minute);
  assign ring_after = ring_r || (match && (in_ch.time_second == 6'd0));
  assign tick_start = ring_after && match && !ring_r;
  assign tick_stop  = ring_after && !match;
  assign tick_scan  = tick_stop || (in_ch.rescan && !tick_start);

  always_comb begin
    case (act)
      was_pkg::ACT_WRITE: go_scan = 1'b1;
      was_pkg::ACT_TICK:  go_scan = tick_scan;
      was_pkg::ACT_STOP:  go_scan = 1'b1;
      default:            go_scan = 1'b0;
    endcase
  end

  assign dist_raw  = base_r + $signed({2'b00, day_off_r});
  assign dist_wrap = dist_raw[was_pkg::DIST_W-1] ? dist_raw + was_pkg::WEEK_WRAP : dist_raw;
  assign cand      = ent_r.enabled && ent_r.days[day_r];
  assign better    = cand && ($unsigned(dist_wrap) < best_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      was_pkg::ST_IDLE: begin
        if (accept) state_nxt = go_scan ? was_pkg::ST_NOW : was_pkg::ST_RESP;
      end
      was_pkg::ST_NOW:  state_nxt = was_pkg::ST_LOAD;
      was_pkg::ST_LOAD: begin
        state_nxt = (slot_cnt_r == SLOTS_CNT) ? was_pkg::ST_RESP : was_pkg::ST_DAY;
      end
      was_pkg::ST_DAY: begin
        if (day_r == was_pkg::LAST_DAY) state_nxt = was_pkg::ST_LOAD;
      end
      was_pkg::ST_RESP: begin
        if (out_free) state_nxt = was_pkg::ST_IDLE;
      end
      default:          state_nxt = was_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    tbl_we           = 1'b0;
    tbl_idx          = in_ch.slot[IDX_W-1:0];
    tbl_wdata        = '{enabled: in_ch.alarm_enabled, days: in_ch.alarm_days,
                         hour: in_ch.alarm_hour, minute: in_ch.alarm_minute};
    cur_hour_nxt     = cur_hour_r;
    cur_min_nxt      = cur_min_r;
    cur_wday_nxt     = cur_wday_r;
    chosen_valid_nxt = chosen_valid_r;
    chosen_slot_nxt  = chosen_slot_r;
    chosen_day_nxt   = chosen_day_r;
    chosen_days_nxt  = chosen_days_r;
    chosen_hour_nxt  = chosen_hour_r;
    chosen_min_nxt   = chosen_min_r;
    ring_nxt         = ring_r;
    started_nxt      = started_r;
    now_nxt          = now_r;
    best_nxt         = best_r;
    base_nxt         = base_r;
    day_off_nxt      = day_off_r;
    day_nxt          = day_r;
    slot_cnt_nxt     = slot_cnt_r;
    ent_nxt          = ent_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_found_nxt    = out_found_r;
    out_slot_nxt     = out_slot_r;
    out_wday_nxt     = out_wday_r;
    out_ring_nxt     = out_ring_r;
    out_started_nxt  = out_started_r;

    case (state_r)
      was_pkg::ST_IDLE: begin
        if (accept) begin
          started_nxt = 1'b0;
          case (act)
            was_pkg::ACT_WRITE: begin
              tbl_we = ({1'b0, in_ch.slot} < SLOTS_4);
            end
            was_pkg::ACT_TICK: begin
              cur_hour_nxt = in_ch.time_hour;
              cur_min_nxt  = in_ch.time_minute;
              cur_wday_nxt = in_ch.weekday;
              ring_nxt     = ring_after && !tick_stop;
              started_nxt  = tick_start;
            end
            was_pkg::ACT_STOP: begin
              ring_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      was_pkg::ST_NOW: begin
        now_nxt          = cur_wday_r * was_pkg::MIN_PER_DAY +
                           cur_hour_r * was_pkg::MIN_PER_HOUR +
                           was_pkg::NOW_W'(cur_min_r) + 14'd1;
        best_nxt         = was_pkg::DIST_MAX;
        chosen_valid_nxt = 1'b0;
        chosen_slot_nxt  = 3'd0;
        chosen_day_nxt   = 3'd0;
        slot_cnt_nxt     = '0;
      end
      was_pkg::ST_LOAD: begin
        ent_nxt     = table_r[slot_cnt_r[IDX_W-1:0]];
        // time of day of the entry, relative to the search start
        base_nxt    = $signed(was_pkg::DIST_W'(table_r[slot_cnt_r[IDX_W-1:0]].hour) *
                              was_pkg::DIST_W'(was_pkg::MIN_PER_HOUR) +
                              was_pkg::DIST_W'(table_r[slot_cnt_r[IDX_W-1:0]].minute) -
                              was_pkg::DIST_W'(now_r));
        day_nxt     = 3'd0;
        day_off_nxt = '0;
      end
      was_pkg::ST_DAY: begin
        if (better) begin
          best_nxt         = $unsigned(dist_wrap);
          chosen_valid_nxt = 1'b1;
          chosen_slot_nxt  = 3'(slot_cnt_r);
          chosen_day_nxt   = day_r;
          chosen_days_nxt  = ent_r.days;
          chosen_hour_nxt  = ent_r.hour;
          chosen_min_nxt   = ent_r.minute;
        end
        day_nxt     = day_r + 3'd1;
        day_off_nxt = day_off_r + was_pkg::MIN_PER_DAY;
        if (day_r == was_pkg::LAST_DAY) slot_cnt_nxt = slot_cnt_r + CNT_W'(1);
      end
      was_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_found_nxt   = chosen_valid_r;
          out_slot_nxt    = chosen_slot_r;
          out_wday_nxt    = chosen_day_r;
          out_ring_nxt    = ring_r;
          out_started_nxt = started_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= was_pkg::ST_IDLE;
      for (int i = 0; i < ALARM_SLOTS; i++) table_r[i] <= '0;
      cur_hour_r     <= '0;
      cur_min_r      <= '0;
      cur_wday_r     <= '0;
      chosen_valid_r <= 1'b0;
      chosen_slot_r  <= '0;
      chosen_day_r   <= '0;
      ring_r         <= 1'b0;
      started_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (tbl_we) table_r[tbl_idx] <= tbl_wdata;
      cur_hour_r     <= cur_hour_nxt;
      cur_min_r      <= cur_min_nxt;
      cur_wday_r     <= cur_wday_nxt;
      chosen_valid_r <= chosen_valid_nxt;
      chosen_slot_r  <= chosen_slot_nxt;
      chosen_day_r   <= chosen_day_nxt;
      ring_r         <= ring_nxt;
      started_r      <= started_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chosen_days_r <= chosen_days_nxt;
    chosen_hour_r <= chosen_hour_nxt;
    chosen_min_r  <= chosen_min_nxt;
    now_r         <= now_nxt;
    best_r        <= best_nxt;
    base_r        <= base_nxt;
    day_off_r     <= day_off_nxt;
    day_r         <= day_nxt;
    slot_cnt_r    <= slot_cnt_nxt;
    ent_r         <= ent_nxt;
    out_found_r   <= out_found_nxt;
    out_slot_r    <= out_slot_nxt;
    out_wday_r    <= out_wday_nxt;
    out_ring_r    <= out_ring_nxt;
    out_started_r <= out_started_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.next_found   = out_found_r;
  assign out_ch.next_slot    = out_slot_r;
  assign out_ch.next_weekday = out_wday_r;
  assign out_ch.ringing      = out_ring_r;
  assign out_ch.ring_started = out_started_r;

endmodule
